// File: rtl/scwa_pkg.sv
// Package for the scan crop / window average block.
// Register map, configuration struct, FSM states and reset values; no dependencies.
package scwa_pkg;

	localparam int unsigned RANGE_W   = 16;
	localparam int unsigned ANGLE_W   = 32;
	localparam int unsigned STEP_W    = 16;
	localparam int unsigned WSIZE_W   = 7;
	localparam int unsigned KEPT_W    = 13;
	localparam int unsigned CPOS_W    = 12;
	localparam int unsigned ADDR_W    = 5;
	localparam int unsigned IDX_W     = 3;

	localparam int unsigned MAX_WINDOW_DEF  = 64;
	localparam int unsigned MAX_SAMPLES_DEF = 4096;

	localparam logic [RANGE_W-1:0] RANGE_UPPER_RST = 16'hFFFF;
	localparam logic [RANGE_W-1:0] RANGE_LOWER_RST = 16'h0000;
	localparam logic [ANGLE_W-1:0] ANGLE_UPPER_RST = 32'h7FFF_FFFF;
	localparam logic [ANGLE_W-1:0] ANGLE_LOWER_RST = 32'h8000_0000;
	localparam logic [STEP_W-1:0]  ANGLE_STEP_RST  = 16'd4096;
	localparam logic [WSIZE_W-1:0] WINDOW_SIZE_RST = 7'd4;

	typedef enum logic [IDX_W-1:0] {
		REG_RANGE_UPPER = 3'd0,
		REG_RANGE_LOWER = 3'd1,
		REG_ANGLE_UPPER = 3'd2,
		REG_ANGLE_LOWER = 3'd3,
		REG_ANGLE_STEP  = 3'd4,
		REG_WINDOW_SIZE = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [RANGE_W-1:0] range_upper;
		logic [RANGE_W-1:0] range_lower;
		logic [ANGLE_W-1:0] angle_upper;
		logic [ANGLE_W-1:0] angle_lower;
		logic [STEP_W-1:0]  angle_step;
		logic [WSIZE_W-1:0] window_size;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_SUM,
		ST_DIV,
		ST_EMIT
	} state_t;

endpackage

// File: rtl/scwa_regs.sv
// APB configuration registers of the scan crop / window average block.
// Depends on scwa_pkg.
module scwa_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [scwa_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	output scwa_pkg::cfg_t               cfg
);
	import scwa_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.range_upper <= RANGE_UPPER_RST;
			cfg_q.range_lower <= RANGE_LOWER_RST;
			cfg_q.angle_upper <= ANGLE_UPPER_RST;
			cfg_q.angle_lower <= ANGLE_LOWER_RST;
			cfg_q.angle_step  <= ANGLE_STEP_RST;
			cfg_q.window_size <= WINDOW_SIZE_RST;
		end else if (wr_en) begin
			case (idx)
				REG_RANGE_UPPER: cfg_q.range_upper <= pwdata[RANGE_W-1:0];
				REG_RANGE_LOWER: cfg_q.range_lower <= pwdata[RANGE_W-1:0];
				REG_ANGLE_UPPER: cfg_q.angle_upper <= pwdata[ANGLE_W-1:0];
				REG_ANGLE_LOWER: cfg_q.angle_lower <= pwdata[ANGLE_W-1:0];
				REG_ANGLE_STEP:  cfg_q.angle_step  <= pwdata[STEP_W-1:0];
				REG_WINDOW_SIZE: cfg_q.window_size <= pwdata[WSIZE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_RANGE_UPPER: prdata = 32'(cfg_q.range_upper);
			REG_RANGE_LOWER: prdata = 32'(cfg_q.range_lower);
			REG_ANGLE_UPPER: prdata = cfg_q.angle_upper;
			REG_ANGLE_LOWER: prdata = cfg_q.angle_lower;
			REG_ANGLE_STEP:  prdata = 32'(cfg_q.angle_step);
			REG_WINDOW_SIZE: prdata = 32'(cfg_q.window_size);
			default:         prdata = 32'd0;
		endcase
	end

endmodule

// File: rtl/scwa_win.sv
// Window storage: range and angle memories, one write port and registered reads.
// Depends on scwa_pkg.
module scwa_win #(
	parameter int unsigned MAX_WINDOW = scwa_pkg::MAX_WINDOW_DEF,
	parameter int unsigned PW         = (MAX_WINDOW > 2) ? $clog2(MAX_WINDOW) : 1
) (
	input  logic                          clk,
	input  logic                          we,
	input  logic [PW-1:0]                 waddr,
	input  logic [scwa_pkg::RANGE_W-1:0]  wrange,
	input  logic [scwa_pkg::ANGLE_W-1:0]  wangle,
	input  logic [PW-1:0]                 raddr_old,
	input  logic [PW-1:0]                 raddr_ctr,
	output logic [scwa_pkg::RANGE_W-1:0]  rd_range,
	output logic [scwa_pkg::ANGLE_W-1:0]  rd_angle
);
	import scwa_pkg::*;

	logic [RANGE_W-1:0] range_mem [MAX_WINDOW];
	logic [ANGLE_W-1:0] angle_mem [MAX_WINDOW];

	always_ff @(posedge clk) begin
		if (we) begin
			range_mem[waddr] <= wrange;
		end
		rd_range <= range_mem[raddr_old];
	end

	always_ff @(posedge clk) begin
		if (we) begin
			angle_mem[waddr] <= wangle;
		end
		rd_angle <= angle_mem[raddr_ctr];
	end

endmodule

// File: rtl/scwa_div.sv
// Restoring divider, one quotient bit per cycle, for the window average.
// Depends on scwa_pkg only through the import convention.
module scwa_div #(
	parameter int unsigned SW = 23,
	parameter int unsigned WW = 7
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [SW-1:0] dividend,
	input  logic [WW-1:0] divisor,
	output logic          done,
	output logic [SW-1:0] quotient
);
	import scwa_pkg::*;

	localparam int unsigned CW = $clog2(SW + 1);

	logic [WW-1:0] rem_q;
	logic [SW-1:0] quo_q;
	logic [WW-1:0] div_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [WW:0]   trial;
	logic          ge;

	assign trial    = {rem_q, quo_q[SW-1]};
	assign ge       = trial >= {1'b0, div_q};
	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(SW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? WW'(trial - {1'b0, div_q}) : trial[WW-1:0];
			quo_q <= {quo_q[SW-2:0], ge};
		end
	end

endmodule

// File: rtl/scan_crop_window_average.sv
// Scan crop / window average top level: stream ports, APB registers, control FSM.
// Per sample: a dropped sample goes IDLE, EVAL; a kept one goes IDLE, EVAL, SUM; an end-of-scan
// result without average adds EMIT (after SUM if the sample is kept); a sample that completes a
// window goes through SUM, DIV (divider width SW = 16 + clog2(MAX_WINDOW+1), 23 at default), EMIT.
// One sample is in flight at a time; the output register lets the next sample enter.
// Reset (arst_n, async): registers to defaults, window empty, scan counters cleared.
module scan_crop_window_average #(
	parameter int unsigned MAX_WINDOW  = scwa_pkg::MAX_WINDOW_DEF,
	parameter int unsigned MAX_SAMPLES = scwa_pkg::MAX_SAMPLES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [15:0]                  s_tdata,  // range_mm[15:0]
	input  logic [0:0]                   s_tuser,  // range_finite[0]
	input  logic                         s_tlast,  // last_in_scan
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [63:0]                  m_tdata,  // average_range_mm[15:0],
	                                               // centre_angle[47:16],
	                                               // centre_position[59:48], zero[63:60]
	output logic [0:0]                   m_tuser,  // average_valid[0]
	output logic                         m_tlast,  // end_of_scan
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [scwa_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);
	import scwa_pkg::*;

	localparam int unsigned PW   = (MAX_WINDOW > 2) ? $clog2(MAX_WINDOW) : 1;
	localparam int unsigned WW   = $clog2(MAX_WINDOW + 1);
	localparam int unsigned SW   = RANGE_W + WW;
	localparam int unsigned PSW  = $clog2(MAX_SAMPLES);
	localparam int unsigned AW   = PSW + STEP_W;
	localparam int unsigned AEXT = 34;
	localparam int unsigned WRST = (MAX_WINDOW < 4) ? MAX_WINDOW : 4;

	cfg_t cfg;

	state_t state_q, state_d;

	logic [RANGE_W-1:0] rng_q;
	logic               fin_q;
	logic               last_q;
	logic [AW-1:0]      prod_q;
	logic [PSW-1:0]     pos_q;
	logic [PW-1:0]      wr_ptr_q;
	logic [WW-1:0]      fill_q;
	logic [WW-1:0]      cnt_q;
	logic [KEPT_W-1:0]  kept_q;
	logic [SW-1:0]      sum_q;
	logic [WW-1:0]      win_w_q;
	logic               keep_q;
	logic               evict_q;
	logic               emit_q;
	logic               fwd_q;
	logic [ANGLE_W-1:0] c_angle_q;
	logic [CPOS_W-1:0]  c_pos_q;

	logic               m_tvalid_q;
	logic [RANGE_W-1:0] o_avg_q;
	logic [ANGLE_W-1:0] o_angle_q;
	logic [CPOS_W-1:0]  o_pos_q;
	logic               o_valid_q;
	logic               o_last_q;

	logic               in_acc;
	logic               out_free;
	logic               load_out;
	logic               div_start;
	logic               div_done;
	logic [SW-1:0]      quotient;
	logic               keep;
	logic               mem_we;
	logic [WW-1:0]      w_clamp;
	logic [WW-1:0]      h;
	logic [WW-1:0]      cnt_dec;
	logic [PW-1:0]      ptr_inc;
	logic [PW:0]        old_t;
	logic [PW:0]        ctr_t;
	logic [PW-1:0]      old_idx;
	logic [PW-1:0]      ctr_idx;
	logic [KEPT_W-1:0]  kept_inc;
	logic [SW-1:0]      sum_new;
	logic [RANGE_W-1:0] rd_range;
	logic [ANGLE_W-1:0] rd_angle;
	logic signed [AEXT-1:0] angle_s;
	logic signed [AEXT-1:0] upper_s;
	logic signed [AEXT-1:0] lower_s;

	scwa_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	scwa_win #(
		.MAX_WINDOW (MAX_WINDOW),
		.PW         (PW)
	) u_win (
		.clk       (clk),
		.we        (mem_we),
		.waddr     (wr_ptr_q),
		.wrange    (rng_q),
		.wangle    (ANGLE_W'(prod_q)),
		.raddr_old (old_idx),
		.raddr_ctr (ctr_idx),
		.rd_range  (rd_range),
		.rd_angle  (rd_angle)
	);

	scwa_div #(
		.SW (SW),
		.WW (WW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_new),
		.divisor  (win_w_q),
		.done     (div_done),
		.quotient (quotient)
	);

	always_comb begin
		if (cfg.window_size < WSIZE_W'(2)) begin
			w_clamp = WW'(2);
		end else if (int'(cfg.window_size) > int'(MAX_WINDOW)) begin
			w_clamp = WW'(MAX_WINDOW);
		end else begin
			w_clamp = WW'(cfg.window_size);
		end
	end

	assign h        = win_w_q >> 1;
	assign angle_s  = $signed({{(AEXT-AW){1'b0}}, prod_q});
	assign upper_s  = AEXT'($signed(cfg.angle_upper));
	assign lower_s  = AEXT'($signed(cfg.angle_lower));
	assign keep     = fin_q && (rng_q < cfg.range_upper) && (rng_q > cfg.range_lower)
	                  && (angle_s > lower_s) && (angle_s < upper_s);
	assign ptr_inc  = (wr_ptr_q == PW'(MAX_WINDOW - 1)) ? '0 : wr_ptr_q + 1'b1;
	assign old_t    = {1'b0, wr_ptr_q} + (PW+1)'(MAX_WINDOW) - (PW+1)'(win_w_q);
	assign old_idx  = (old_t >= (PW+1)'(MAX_WINDOW)) ? PW'(old_t - (PW+1)'(MAX_WINDOW))
	                                                 : old_t[PW-1:0];
	assign ctr_t    = {1'b0, ptr_inc} + (PW+1)'(MAX_WINDOW) - (PW+1)'(win_w_q)
	                  + (PW+1)'(h);
	assign ctr_idx  = (ctr_t >= (PW+1)'(MAX_WINDOW)) ? PW'(ctr_t - (PW+1)'(MAX_WINDOW))
	                                                 : ctr_t[PW-1:0];
	assign kept_inc = kept_q + 1'b1;
	assign cnt_dec  = (cnt_q != '0) ? cnt_q - 1'b1 : '0;
	assign sum_new  = sum_q - (evict_q ? SW'(rd_range) : '0) + SW'(rng_q);

	assign in_acc   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		mem_we    = 1'b0;
		div_start = 1'b0;
		load_out  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) state_d = ST_EVAL;
			end
			ST_EVAL: begin
				if (keep) begin
					mem_we  = 1'b1;
					state_d = ST_SUM;
				end else if (last_q) begin
					state_d = ST_EMIT;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_SUM: begin
				if (emit_q) begin
					div_start = 1'b1;
					state_d   = ST_DIV;
				end else if (last_q) begin
					state_d = ST_EMIT;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_DIV: begin
				if (div_done) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			pos_q    <= '0;
			wr_ptr_q <= '0;
			fill_q   <= '0;
			cnt_q    <= WW'(WRST);
			kept_q   <= '0;
			sum_q    <= '0;
			win_w_q  <= WW'(WRST);
			keep_q   <= 1'b0;
			evict_q  <= 1'b0;
			emit_q   <= 1'b0;
			fwd_q    <= 1'b0;
			last_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_acc) begin
				pos_q  <= (pos_q == PSW'(MAX_SAMPLES - 1)) ? '0 : pos_q + 1'b1;
				last_q <= s_tlast;
			end
			if (state_q == ST_EVAL) begin
				keep_q <= keep;
				emit_q <= keep && (cnt_dec == '0);
				if (keep) begin
					evict_q  <= fill_q >= win_w_q;
					if (fill_q < win_w_q) fill_q <= fill_q + 1'b1;
					wr_ptr_q <= ptr_inc;
					kept_q   <= kept_inc;
					cnt_q    <= (cnt_dec == '0) ? h : cnt_dec;
					fwd_q    <= ctr_idx == wr_ptr_q;
				end
			end
			if (state_q == ST_SUM) begin
				sum_q <= sum_new;
			end
			if (load_out && last_q) begin
				win_w_q  <= w_clamp;
				cnt_q    <= w_clamp;
				sum_q    <= '0;
				kept_q   <= '0;
				pos_q    <= '0;
				wr_ptr_q <= '0;
				fill_q   <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			rng_q  <= s_tdata;
			fin_q  <= s_tuser[0];
			prod_q <= AW'(pos_q) * AW'(cfg.angle_step);
		end
		if (state_q == ST_EVAL && keep) begin
			c_pos_q <= CPOS_W'(kept_inc - KEPT_W'(win_w_q) + KEPT_W'(h));
		end
		if (state_q == ST_SUM) begin
			c_angle_q <= fwd_q ? ANGLE_W'(prod_q) : rd_angle;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			o_valid_q <= keep_q && emit_q;
			o_last_q  <= last_q;
			o_avg_q   <= (keep_q && emit_q) ? quotient[RANGE_W-1:0] : '0;
			o_angle_q <= (keep_q && emit_q) ? c_angle_q : '0;
			o_pos_q   <= (keep_q && emit_q) ? c_pos_q : '0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {4'd0, o_pos_q, o_angle_q, o_avg_q};
	assign m_tuser  = o_valid_q;
	assign m_tlast  = o_last_q;

endmodule

// File: test/scan_crop_window_average_tb.sv
// Testbench for scan_crop_window_average: stream samples in, window averages out, APB setup.
// A scoreboard class predicts each result from its own copy of the registers and scan state.
// Depends on scwa_pkg and the scan_crop_window_average RTL.
`timescale 1ns / 1ps

module scan_crop_window_average_tb;
	import scwa_pkg::*;

	localparam int unsigned SETTLE_CYCLES = 64;
	localparam int unsigned HOLD_CYCLES   = 300;
	localparam longint      CYCLE_LIMIT   = 1500000;

	typedef struct {
		logic [15:0] avg;
		logic [31:0] angle;
		logic [11:0] pos;
		logic        valid;
		logic        eos;
	} scan_result_t;

	class window_avg_scoreboard;
		logic [15:0] range_upper;
		logic [15:0] range_lower;
		logic [31:0] angle_upper;
		logic [31:0] angle_lower;
		logic [15:0] angle_step;
		logic [6:0]  window_size;
		logic [15:0] range_hist [64];
		logic [31:0] angle_hist [64];
		int unsigned run_sum;
		int unsigned kept;
		int unsigned sample_pos;
		int unsigned stride_left;
		int unsigned wr_ptr;
		int unsigned fill;
		int unsigned win_len;
		scan_result_t expected_q [$];
		int errors;

		function new();
			range_upper = RANGE_UPPER_RST;
			range_lower = RANGE_LOWER_RST;
			angle_upper = ANGLE_UPPER_RST;
			angle_lower = ANGLE_LOWER_RST;
			angle_step  = ANGLE_STEP_RST;
			window_size = WINDOW_SIZE_RST;
			errors      = 0;
			start_scan();
		endfunction

		function void start_scan();
			if (window_size < 2)
				win_len = 2;
			else if (window_size > 64)
				win_len = 64;
			else
				win_len = window_size;
			run_sum     = 0;
			kept        = 0;
			sample_pos  = 0;
			stride_left = win_len;
			wr_ptr      = 0;
			fill        = 0;
		endfunction

		function void write_reg(reg_idx_t idx, logic [31:0] val);
			case (idx)
				REG_RANGE_UPPER: range_upper = val[15:0];
				REG_RANGE_LOWER: range_lower = val[15:0];
				REG_ANGLE_UPPER: angle_upper = val;
				REG_ANGLE_LOWER: angle_lower = val;
				REG_ANGLE_STEP:  angle_step  = val[15:0];
				REG_WINDOW_SIZE: window_size = val[6:0];
				default: ;
			endcase
		endfunction

		function logic [31:0] reg_value(reg_idx_t idx);
			case (idx)
				REG_RANGE_UPPER: return {16'd0, range_upper};
				REG_RANGE_LOWER: return {16'd0, range_lower};
				REG_ANGLE_UPPER: return angle_upper;
				REG_ANGLE_LOWER: return angle_lower;
				REG_ANGLE_STEP:  return {16'd0, angle_step};
				REG_WINDOW_SIZE: return {25'd0, window_size};
				default: return 32'd0;
			endcase
		endfunction

		function void report(string msg);
			errors++;
			if (errors <= 100)
				$display("ERROR at %0t: %s", $time, msg);
		endfunction

		// one accepted sample: crop, slide the window, maybe queue a result
		function void add_sample(logic [15:0] rng, logic fin, logic last);
			longint       ang;
			bit           keep;
			int unsigned  w;
			int unsigned  h;
			scan_result_t r;
			w = win_len;
			h = w / 2;
			ang = longint'(sample_pos) * longint'(angle_step);
			keep = fin && (rng < range_upper) && (rng > range_lower) &&
				(ang > longint'($signed(angle_lower))) && (ang < longint'($signed(angle_upper)));
			r.avg = '0;
			r.angle = '0;
			r.pos = '0;
			r.valid = 1'b0;
			r.eos = last;
			sample_pos = (sample_pos + 1) % 4096;
			if (keep) begin
				if (fill >= w)
					run_sum -= range_hist[(wr_ptr + 64 - w) % 64];
				else
					fill++;
				range_hist[wr_ptr] = rng;
				angle_hist[wr_ptr] = ang[31:0];
				run_sum += rng;
				wr_ptr = (wr_ptr + 1) % 64;
				kept = (kept + 1) & 32'h1FFF;
				if (stride_left > 0)
					stride_left--;
				if (stride_left == 0) begin
					r.valid = 1'b1;
					r.avg = 16'(run_sum / w);
					r.angle = angle_hist[(wr_ptr + 64 - w + h) % 64];
					r.pos = 12'((kept + 8192 - w + h) & 32'hFFF);
					stride_left = h;
				end
			end
			if (r.valid || last)
				expected_q.insert(expected_q.size(), r);
			if (last)
				start_scan();
		endfunction

		function void check_result(logic [63:0] data, logic user, logic last);
			scan_result_t e;
			if (expected_q.size() == 0) begin
				report($sformatf("unexpected result data=%h user=%b last=%b", data, user, last));
				return;
			end
			e = expected_q.pop_front();
			if (data[15:0] !== e.avg)
				report($sformatf("average_range_mm %h, expected %h", data[15:0], e.avg));
			if (data[47:16] !== e.angle)
				report($sformatf("centre_angle %h, expected %h", data[47:16], e.angle));
			if (data[59:48] !== e.pos)
				report($sformatf("centre_position %h, expected %h", data[59:48], e.pos));
			if (data[63:60] !== 4'd0)
				report($sformatf("tdata padding %h, expected 0", data[63:60]));
			if (user !== e.valid)
				report($sformatf("average_valid %b, expected %b", user, e.valid));
			if (last !== e.eos)
				report($sformatf("end_of_scan %b, expected %b", last, e.eos));
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic [0:0]  s_tuser = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;
	logic [0:0]  m_tuser;
	logic        m_tlast;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	window_avg_scoreboard sb;
	bit          hold_req = 1'b0;
	bit          steady = 1'b0;
	int unsigned burst_left = 0;
	int unsigned scan_left = 0;
	int unsigned rand_items = 0;
	longint      cycles = 0;

	scan_crop_window_average u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tuser[0], m_tlast);
	end

	// receiver: stall modes of random span; a hold request blocks it for a long stretch
	initial begin
		int unsigned mode;
		int unsigned span;
		forever begin
			span = $urandom_range(20, 200);
			mode = $urandom_range(0, 3);
			repeat (span) begin
				@(negedge clk);
				if (hold_req) begin
					hold_req = 1'b0;
					m_tready <= 1'b0;
					repeat (HOLD_CYCLES) @(negedge clk);
				end else begin
					case (mode)
						0: m_tready <= 1'b1;
						1: m_tready <= 1'($urandom_range(0, 1));
						2: m_tready <= ($urandom_range(0, 3) == 0);
						default: m_tready <= ($urandom_range(0, 7) != 0);
					endcase
				end
			end
		end
	end

	task automatic drive_sample(input logic [15:0] rng, input logic fin, input logic last);
		int unsigned gap;
		int unsigned r;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			r = $urandom_range(0, 3);
			gap = (r == 0 || steady) ? 0 : (r == 3) ? $urandom_range(7, 40) : $urandom_range(1, 6);
			if (gap > 0) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= rng;
		s_tuser  <= fin;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.add_sample(rng, fin, last);
	endtask

	function automatic logic [15:0] pick_range();
		int unsigned lo;
		int unsigned hi;
		int unsigned r;
		lo = sb.range_lower;
		hi = sb.range_upper;
		r = $urandom_range(0, 19);
		if (r < 14 && hi > lo + 1)
			return 16'($urandom_range(lo + 1, hi - 1));
		if (r < 16) begin
			case ($urandom_range(0, 3))
				0: return 16'h0000;
				1: return 16'hFFFF;
				2: return lo[15:0];
				default: return hi[15:0];
			endcase
		end
		return 16'($urandom());
	endfunction

	task automatic scan_sample();
		int unsigned r;
		if (scan_left == 0) begin
			r = $urandom_range(0, 19);
			scan_left = (r < 16) ? $urandom_range(1, 40) : $urandom_range(41, 200);
		end
		scan_left--;
		rand_items++;
		drive_sample(pick_range(), ($urandom_range(0, 9) != 0), (scan_left == 0));
	endtask

	task automatic wait_drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic read_check(input reg_idx_t idx);
		logic [31:0] got;
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		got = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (got !== sb.reg_value(idx))
			sb.report($sformatf("register %s reads %h, expected %h", idx.name(), got,
				sb.reg_value(idx)));
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		sb.write_reg(idx, val);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		read_check(idx);
	endtask

	task automatic load_config(input logic [31:0] up, input logic [31:0] lo,
			input logic [31:0] aup, input logic [31:0] alow,
			input logic [31:0] step, input logic [31:0] wsize);
		write_reg(REG_RANGE_UPPER, up);
		write_reg(REG_RANGE_LOWER, lo);
		write_reg(REG_ANGLE_UPPER, aup);
		write_reg(REG_ANGLE_LOWER, alow);
		write_reg(REG_ANGLE_STEP, step);
		write_reg(REG_WINDOW_SIZE, wsize);
	endtask

	task automatic random_config();
		int unsigned lo;
		int unsigned hi;
		int unsigned s;
		int unsigned w;
		int unsigned r;
		logic [31:0] aup;
		logic [31:0] alow;
		if ($urandom_range(0, 9) < 6) begin
			lo = 0;
			hi = 65535;
		end else begin
			lo = $urandom_range(0, 30000);
			hi = $urandom_range(lo, 65535);
		end
		r = $urandom_range(0, 9);
		s = (r == 0) ? 0 : (r == 1) ? 65535 : (r < 4) ? $urandom_range(0, 65535) :
			$urandom_range(256, 8192);
		r = $urandom_range(0, 19);
		aup = (r < 12) ? 32'h7FFF_FFFF : (r < 17) ? $urandom_range(s * 10, s * 400) : $urandom();
		r = $urandom_range(0, 9);
		alow = (r < 6) ? 32'h8000_0000 : (r < 8) ? 32'($urandom_range(0, s * 30 + 100)) - 32'd100 :
			$urandom();
		r = $urandom_range(0, 9);
		w = (r < 5) ? $urandom_range(2, 8) : (r < 8) ? $urandom_range(9, 64) : $urandom_range(0, 127);
		load_config(hi, lo, aup, alow, s, w);
	endtask

	initial begin
		int i;
		int n;
		sb = new();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		for (i = 0; i < 6; i++)
			read_check(reg_idx_t'(i));

		// reset settings: one-sample scan with no window, then range limits and finite flag
		drive_sample(16'd100, 1'b1, 1'b1);
		drive_sample(16'h0000, 1'b1, 1'b0);
		drive_sample(16'hFFFF, 1'b1, 1'b0);
		drive_sample(16'd5000, 1'b0, 1'b0);
		drive_sample(16'd1, 1'b1, 1'b0);
		drive_sample(16'hFFFE, 1'b1, 1'b0);
		drive_sample(16'd300, 1'b1, 1'b0);
		drive_sample(16'd400, 1'b1, 1'b0);
		drive_sample(16'hFFFE, 1'b1, 1'b0);
		drive_sample(16'd500, 1'b1, 1'b0);
		drive_sample(16'd7, 1'b1, 1'b1);
		drive_sample(16'd1000, 1'b1, 1'b0);
		drive_sample(16'd1000, 1'b1, 1'b0);
		drive_sample(16'd1000, 1'b1, 1'b0);
		wait_drain();
		// window change mid-scan holds until the scan ends
		write_reg(REG_WINDOW_SIZE, 32'd0);
		drive_sample(16'd2000, 1'b1, 1'b0);
		drive_sample(16'd3000, 1'b1, 1'b1);
		drive_sample(16'd10, 1'b1, 1'b0);
		drive_sample(16'd20, 1'b1, 1'b0);
		drive_sample(16'd30, 1'b1, 1'b1);
		wait_drain();

		// register extremes, each followed by random scans
		for (i = 0; i < 6; i++) begin
			case (i)
				0: load_config(65535, 0, 32'h7FFF_FFFF, 32'h8000_0000, 65535, 64);
				1: load_config(0, 65535, 32'h7FFF_FFFF, 32'h8000_0000, 0, 127);
				2: load_config(40000, 100, 32'h8000_0000, 32'h7FFF_FFFF, 1, 1);
				3: load_config(65535, 0, 4096 * 40, 4096 * 5, 4096, 65);
				4: load_config(65535, 0, 32'd1, 32'hFFFF_FFFF, 0, 3);
				default: load_config(65535, 0, 32'h7FFF_FFFF, 32'd0, 0, 2);
			endcase
			n = (i == 0) ? 120 : 40;
			repeat (n) scan_sample();
			wait_drain();
		end

		// output held off while the sender keeps offering
		load_config(65535, 0, 32'h7FFF_FFFF, 32'h8000_0000, 4096, 2);
		steady = 1'b1;
		hold_req = 1'b1;
		repeat (80) drive_sample(16'($urandom_range(1, 65534)), 1'b1, 1'b0);
		steady = 1'b0;
		wait_drain();

		// long scan: many windows and strides in one scan
		load_config(65535, 0, 32'h7FFF_FFFF, 32'h8000_0000, 65535, 8);
		for (i = 0; i < 300; i++)
			drive_sample(16'($urandom_range(1, 65534)), 1'b1, (i == 299));
		scan_left = 0;
		wait_drain();

		rand_items = 0;
		while (rand_items < 650) begin
			random_config();
			n = $urandom_range(30, 150);
			repeat (n) scan_sample();
			wait_drain();
		end

		wait_drain();
		if (sb.pending() != 0)
			sb.report($sformatf("%0d results never arrived", sb.pending()));
		if (sb.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
